// ===== design/ecdsa_der_signature_to_raw_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros used by the checker of the DER signature converter.
// ----------------------------------------------------------------------------
`ifndef ECDSA_DER_SIGNATURE_TO_RAW_MACROS_SVH
`define ECDSA_DER_SIGNATURE_TO_RAW_MACROS_SVH

// Same-cycle implication, off while reset is held.
`define DSR_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("dsr assertion failed");

// Next-cycle implication, off while reset is held.
`define DSR_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("dsr assertion failed");

// What must hold in the cycle after reset is sampled low.
`define DSR_ASSERT_RST(lbl, clk, rst_n, cons) \
    lbl: assert property (@(posedge clk) (!rst_n) |=> (cons)) \
        else $error("dsr reset assertion failed");

`endif

// ===== design/dsr_pkg.sv =====
// ----------------------------------------------------------------------------
// dsr_pkg
// Shared constants and types of the DER signature to raw r||s converter.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package dsr_pkg;

    // Default integer size (P-256) and byte counter width.
    localparam int INT_BYTES_DEF  = 32;
    localparam int COUNT_BITS_DEF = 9;

    // Width of a start offset or write position; covers integers up to 66 bytes.
    localparam int START_W = 7;

    localparam logic [7:0] TAG_SEQUENCE = 8'h30;
    localparam logic [7:0] TAG_INTEGER  = 8'h02;
    localparam logic [7:0] ZERO_BYTE    = 8'h00;
    localparam int         MIN_SIG_BYTES = 6;

    // One finished signature handed from the parser to the emitter.
    typedef struct packed {
        logic               failed;
        logic               bank;
        logic [START_W-1:0] r_start;
        logic [START_W-1:0] s_start;
    } t_job;

    // Buffer write request from the parser.
    typedef struct packed {
        logic               en;
        logic               bank;
        logic               half;
        logic [START_W-1:0] pos;
        logic [7:0]         data;
    } t_wr;

endpackage

`default_nettype wire

// ===== design/dsr_front.sv =====
// ----------------------------------------------------------------------------
// dsr_front
// DER parser: takes one byte per request, writes integer bytes into the
// buffer bank in use and posts a job on the final byte.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module dsr_front #(
    parameter int INT_BYTES  = dsr_pkg::INT_BYTES_DEF,
    parameter int COUNT_BITS = dsr_pkg::COUNT_BITS_DEF
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_take,
    input  wire logic [7:0]  i_sig_byte,
    input  wire logic        i_end_of_sig,
    output dsr_pkg::t_job    o_job,
    output logic             o_job_push,
    output dsr_pkg::t_wr     o_wr
);

    localparam int SW    = dsr_pkg::START_W;
    localparam int CMP_W = (COUNT_BITS > 9) ? COUNT_BITS : 9;

    localparam logic [2:0] PH_SEQ_TAG  = 3'd0;
    localparam logic [2:0] PH_SEQ_LEN  = 3'd1;
    localparam logic [2:0] PH_INT_TAG  = 3'd2;
    localparam logic [2:0] PH_INT_LEN  = 3'd3;
    localparam logic [2:0] PH_INT_DATA = 3'd4;
    localparam logic [2:0] PH_DONE     = 3'd5;

    localparam logic [COUNT_BITS-1:0] COUNT_MAX = {COUNT_BITS{1'b1}};
    localparam logic [SW-1:0]         INT_END   = SW'(INT_BYTES);

    logic [2:0]            r_phase,   n_phase;
    logic [COUNT_BITS-1:0] r_count,   n_count;
    logic [7:0]            r_seq_len, n_seq_len;
    logic [7:0]            r_left,    n_left;
    logic                  r_first,   n_first;
    logic                  r_second,  n_second;
    logic [SW-1:0]         r_r_start, n_r_start;
    logic [SW-1:0]         r_s_start, n_s_start;
    logic [SW-1:0]         r_wpos,    n_wpos;
    logic                  r_err,     n_err;
    logic                  r_bank,    n_bank;

    always_comb begin
        logic             drop;
        logic             keep;
        logic             stop;
        logic [7:0]       dlen;
        logic [7:0]       left_dec;
        logic [SW-1:0]    start;
        logic [SW-1:0]    pos;
        logic [CMP_W-1:0] cnt_ext;
        logic [CMP_W-1:0] need;

        n_phase   = r_phase;
        n_count   = r_count;
        n_seq_len = r_seq_len;
        n_left    = r_left;
        n_first   = r_first;
        n_second  = r_second;
        n_r_start = r_r_start;
        n_s_start = r_s_start;
        n_wpos    = r_wpos;
        n_err     = r_err;
        n_bank    = r_bank;
        o_wr      = '0;
        o_job     = '0;
        o_job_push = 1'b0;
        drop      = 1'b0;
        keep      = 1'b1;
        stop      = 1'b0;
        dlen      = r_left;
        left_dec  = 8'd0;
        start     = INT_END;
        pos       = r_wpos;
        cnt_ext   = '0;
        need      = '0;

        if (i_take) begin
            if (r_count != COUNT_MAX) begin
                n_count = r_count + 1'b1;
            end
            if (!r_err) begin
                case (r_phase)
                    PH_SEQ_TAG: begin
                        if (i_sig_byte != dsr_pkg::TAG_SEQUENCE) begin
                            n_err = 1'b1;
                        end else begin
                            n_phase = PH_SEQ_LEN;
                        end
                    end
                    PH_SEQ_LEN: begin
                        n_seq_len = i_sig_byte;
                        n_phase   = PH_INT_TAG;
                    end
                    PH_INT_TAG: begin
                        if (i_sig_byte != dsr_pkg::TAG_INTEGER) begin
                            n_err = 1'b1;
                        end else begin
                            n_phase = PH_INT_LEN;
                        end
                    end
                    PH_INT_LEN: begin
                        n_left = i_sig_byte;
                        if (i_sig_byte == dsr_pkg::ZERO_BYTE) begin
                            // Empty integer: value is all zeros.
                            if (r_second) begin
                                n_s_start = INT_END;
                                n_phase   = PH_DONE;
                            end else begin
                                n_r_start = INT_END;
                                n_second  = 1'b1;
                                n_phase   = PH_INT_TAG;
                            end
                            n_wpos = INT_END;
                        end else begin
                            n_first = 1'b1;
                            n_phase = PH_INT_DATA;
                        end
                    end
                    PH_INT_DATA: begin
                        if (r_first) begin
                            drop    = (r_left > 8'd1) && (i_sig_byte == dsr_pkg::ZERO_BYTE);
                            dlen    = drop ? (r_left - 8'd1) : r_left;
                            n_first = 1'b0;
                            if (dlen > 8'(INT_BYTES)) begin
                                n_err = 1'b1;
                                stop  = 1'b1;
                            end else begin
                                start = INT_END - SW'(dlen);
                                if (r_second) begin
                                    n_s_start = start;
                                end else begin
                                    n_r_start = start;
                                end
                                n_wpos = start;
                                pos    = start;
                                keep   = !drop;
                            end
                        end
                        if (!stop) begin
                            if (keep && (pos < INT_END)) begin
                                o_wr.en   = 1'b1;
                                o_wr.bank = r_bank;
                                o_wr.half = r_second;
                                o_wr.pos  = pos;
                                o_wr.data = i_sig_byte;
                                n_wpos    = pos + 1'b1;
                            end
                            left_dec = (r_left != 8'd0) ? (r_left - 8'd1) : 8'd0;
                            n_left   = left_dec;
                            if (left_dec == 8'd0) begin
                                if (r_second) begin
                                    n_phase = PH_DONE;
                                end else begin
                                    n_second = 1'b1;
                                    n_phase  = PH_INT_TAG;
                                end
                            end
                        end
                    end
                    default: begin
                    end
                endcase
            end

            if (i_end_of_sig) begin
                cnt_ext = CMP_W'(n_count);
                need    = CMP_W'(n_seq_len) + CMP_W'(2);
                o_job_push    = 1'b1;
                o_job.bank    = r_bank;
                o_job.r_start = n_r_start;
                o_job.s_start = n_s_start;
                o_job.failed  = !(!n_err && (n_phase == PH_DONE) &&
                                  (cnt_ext >= CMP_W'(dsr_pkg::MIN_SIG_BYTES)) &&
                                  (need <= cnt_ext));
                // Next signature goes to the other bank.
                n_bank    = ~r_bank;
                n_phase   = PH_SEQ_TAG;
                n_count   = '0;
                n_seq_len = 8'd0;
                n_left    = 8'd0;
                n_first   = 1'b0;
                n_second  = 1'b0;
                n_r_start = INT_END;
                n_s_start = INT_END;
                n_wpos    = '0;
                n_err     = 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase   <= PH_SEQ_TAG;
            r_count   <= '0;
            r_seq_len <= 8'd0;
            r_left    <= 8'd0;
            r_first   <= 1'b0;
            r_second  <= 1'b0;
            r_r_start <= INT_END;
            r_s_start <= INT_END;
            r_wpos    <= '0;
            r_err     <= 1'b0;
            r_bank    <= 1'b0;
        end else begin
            r_phase   <= n_phase;
            r_count   <= n_count;
            r_seq_len <= n_seq_len;
            r_left    <= n_left;
            r_first   <= n_first;
            r_second  <= n_second;
            r_r_start <= n_r_start;
            r_s_start <= n_s_start;
            r_wpos    <= n_wpos;
            r_err     <= n_err;
            r_bank    <= n_bank;
        end
    end

endmodule

`default_nettype wire

// ===== design/dsr_job_fifo.sv =====
// ----------------------------------------------------------------------------
// dsr_job_fifo
// Two-entry queue of finished signatures between the parser and the emitter.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module dsr_job_fifo (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_push,
    input  wire dsr_pkg::t_job i_job,
    input  wire logic          i_pop,
    output dsr_pkg::t_job      o_job,
    output logic [1:0]         o_count
);

    dsr_pkg::t_job r_entry [2];
    logic          r_wr_ptr, n_wr_ptr;
    logic          r_rd_ptr, n_rd_ptr;
    logic [1:0]    r_count,  n_count;

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (i_push) begin
            n_wr_ptr = ~r_wr_ptr;
        end
        if (i_pop) begin
            n_rd_ptr = ~r_rd_ptr;
        end
        if (i_push && !i_pop) begin
            n_count = r_count + 2'd1;
        end else if (!i_push && i_pop) begin
            n_count = r_count - 2'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_count  <= 2'd0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_entry[r_wr_ptr] <= i_job;
        end
    end

    assign o_job   = r_entry[r_rd_ptr];
    assign o_count = r_count;

endmodule

`default_nettype wire

// ===== design/dsr_back.sv =====
// ----------------------------------------------------------------------------
// dsr_back
// Emitter: owns the two-bank byte buffer and plays out r||s, or one error
// result, for each job through a registered output stage.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module dsr_back #(
    parameter int INT_BYTES = dsr_pkg::INT_BYTES_DEF
) (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire dsr_pkg::t_wr  i_wr,
    input  wire logic          i_job_avail,
    input  wire dsr_pkg::t_job i_job,
    output logic               o_job_pop,
    output logic               o_busy,
    output logic [7:0]         o_raw_byte,
    output logic [5:0]         o_raw_index,
    output logic               o_final_result,
    output logic               o_failed,
    output logic               o_empty,
    input  wire logic          i_pop
);

    localparam int SW     = dsr_pkg::START_W;
    localparam int IDX_W  = (INT_BYTES > 1) ? $clog2(INT_BYTES) : 1;
    localparam int ADDR_W = IDX_W + 2;
    localparam int DEPTH  = 1 << ADDR_W;
    localparam int KW     = $clog2(2 * INT_BYTES);
    localparam logic [KW-1:0] K_HALF = KW'(INT_BYTES);
    localparam logic [KW-1:0] K_LAST = KW'(2 * INT_BYTES - 1);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_READ = 2'd1;
    localparam logic [1:0] ST_LOAD = 2'd2;
    localparam logic [1:0] ST_OUT  = 2'd3;

    logic [7:0]        mem [DEPTH];
    logic [7:0]        r_rd_data;

    logic [1:0]        r_state, n_state;
    logic [KW-1:0]     r_k,     n_k;
    dsr_pkg::t_job     r_job,   n_job;
    logic [7:0]        r_out_byte,  n_out_byte;
    logic [5:0]        r_out_index, n_out_index;
    logic              r_out_final, n_out_final;
    logic              r_out_fail,  n_out_fail;

    logic              half;
    logic [SW-1:0]     j;
    logic [ADDR_W-1:0] rd_addr;
    logic [ADDR_W-1:0] wr_addr;

    assign half    = (r_k >= K_HALF);
    assign j       = half ? SW'(r_k - K_HALF) : SW'(r_k);
    assign rd_addr = {r_job.bank, half, j[IDX_W-1:0]};
    assign wr_addr = {i_wr.bank, i_wr.half, i_wr.pos[IDX_W-1:0]};

    always_ff @(posedge i_clk) begin
        if (i_wr.en) begin
            mem[wr_addr] <= i_wr.data;
        end
        r_rd_data <= mem[rd_addr];
    end

    always_comb begin
        logic [SW-1:0] start;

        n_state     = r_state;
        n_k         = r_k;
        n_job       = r_job;
        n_out_byte  = r_out_byte;
        n_out_index = r_out_index;
        n_out_final = r_out_final;
        n_out_fail  = r_out_fail;
        o_job_pop   = 1'b0;
        start       = half ? r_job.s_start : r_job.r_start;

        case (r_state)
            ST_IDLE: begin
                if (i_job_avail) begin
                    o_job_pop = 1'b1;
                    n_job     = i_job;
                    n_k       = '0;
                    if (i_job.failed) begin
                        n_out_byte  = 8'd0;
                        n_out_index = 6'd0;
                        n_out_final = 1'b1;
                        n_out_fail  = 1'b1;
                        n_state     = ST_OUT;
                    end else begin
                        n_state = ST_READ;
                    end
                end
            end
            ST_READ: begin
                n_state = ST_LOAD;
            end
            ST_LOAD: begin
                // Bytes left of the integer's start were never written; show zero.
                n_out_byte  = (j >= start) ? r_rd_data : 8'd0;
                n_out_index = 6'(r_k);
                n_out_final = (r_k == K_LAST);
                n_out_fail  = 1'b0;
                n_state     = ST_OUT;
            end
            ST_OUT: begin
                if (i_pop) begin
                    if (r_out_final) begin
                        n_state = ST_IDLE;
                    end else begin
                        n_k     = r_k + 1'b1;
                        n_state = ST_READ;
                    end
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
        r_k         <= n_k;
        r_job       <= n_job;
        r_out_byte  <= n_out_byte;
        r_out_index <= n_out_index;
        r_out_final <= n_out_final;
        r_out_fail  <= n_out_fail;
    end

    assign o_busy         = (r_state != ST_IDLE);
    assign o_empty        = (r_state != ST_OUT);
    assign o_raw_byte     = r_out_byte;
    assign o_raw_index    = r_out_index;
    assign o_final_result = r_out_final;
    assign o_failed       = r_out_fail;

endmodule

`default_nettype wire

// ===== design/ecdsa_der_signature_to_raw.sv =====
// Input: one DER byte per cycle while fewer than two signatures await output.
// Output: 2*INT_BYTES results per good signature, each through buffer read, load
// and present steps, the next only after a pop; a failed signature gives one result.
// The final byte's job passes the job queue first; an error result skips read and load.
// Synchronous active-low reset clears FSM and count state; buffer and data regs are not.
// ----------------------------------------------------------------------------
// ecdsa_der_signature_to_raw
// Converts a DER ECDSA signature into raw big-endian r||s bytes.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module ecdsa_der_signature_to_raw #(
    parameter int INT_BYTES  = dsr_pkg::INT_BYTES_DEF,
    parameter int COUNT_BITS = dsr_pkg::COUNT_BITS_DEF
) (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic [7:0] i_sig_byte,
    input  wire logic       i_end_of_sig,
    input  wire logic       push,
    output logic            full,
    output logic [7:0]      o_raw_byte,
    output logic [5:0]      o_raw_index,
    output logic            o_final_result,
    output logic            o_failed,
    output logic            empty,
    input  wire logic       pop
);

    dsr_pkg::t_job job_in;
    dsr_pkg::t_job job_out;
    dsr_pkg::t_wr  wr;
    logic          job_push;
    logic          job_pop;
    logic [1:0]    job_count;
    logic          busy;
    logic          take;

    // Each pending or active signature holds one buffer bank; there are two.
    assign full = ({1'b0, job_count} + {2'b00, busy}) >= 3'd2;
    assign take = push && !full;

    dsr_front #(
        .INT_BYTES  (INT_BYTES),
        .COUNT_BITS (COUNT_BITS)
    ) u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_take       (take),
        .i_sig_byte   (i_sig_byte),
        .i_end_of_sig (i_end_of_sig),
        .o_job        (job_in),
        .o_job_push   (job_push),
        .o_wr         (wr)
    );

    dsr_job_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (job_push),
        .i_job   (job_in),
        .i_pop   (job_pop),
        .o_job   (job_out),
        .o_count (job_count)
    );

    dsr_back #(
        .INT_BYTES (INT_BYTES)
    ) u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_wr           (wr),
        .i_job_avail    (job_count != 2'd0),
        .i_job          (job_out),
        .o_job_pop      (job_pop),
        .o_busy         (busy),
        .o_raw_byte     (o_raw_byte),
        .o_raw_index    (o_raw_index),
        .o_final_result (o_final_result),
        .o_failed       (o_failed),
        .o_empty        (empty),
        .i_pop          (pop)
    );

endmodule

`default_nettype wire

// ===== design/dsr_checker.sv =====
// ----------------------------------------------------------------------------
// dsr_checker
// Port-level checks of the DER signature converter, bound to the top level.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

`include "ecdsa_der_signature_to_raw_macros.svh"

module dsr_checker #(
    parameter int INT_BYTES = dsr_pkg::INT_BYTES_DEF
) (
    input wire logic       i_clk,
    input wire logic       i_rst_n,
    input wire logic       full,
    input wire logic [7:0] o_raw_byte,
    input wire logic [5:0] o_raw_index,
    input wire logic       o_final_result,
    input wire logic       o_failed,
    input wire logic       empty,
    input wire logic       pop
);

    localparam logic [5:0] LAST_INDEX = 6'(2 * INT_BYTES - 1);

    logic        waiting;
    logic        fail_shape_ok;
    logic        last_ok;
    logic [15:0] result_bits;

    assign waiting       = !empty && !pop;
    assign fail_shape_ok = o_final_result && (o_raw_byte == 8'd0) && (o_raw_index == 6'd0);
    assign last_ok       = (o_raw_index == LAST_INDEX);
    assign result_bits   = {o_raw_byte, o_raw_index, o_final_result, o_failed};

    // A result not taken stays in place.
    `DSR_ASSERT_NXT(a_hold, i_clk, i_rst_n, waiting, !empty && $stable(result_bits))

    // An error request is a single zero result that closes the signature.
    `DSR_ASSERT_IMP(a_fail_shape, i_clk, i_rst_n, !empty && o_failed, fail_shape_ok)

    // A good signature ends on the last s byte.
    `DSR_ASSERT_IMP(a_last_index, i_clk, i_rst_n, !empty && o_final_result && !o_failed, last_ok)

    // Reset leaves nothing queued and the input open.
    `DSR_ASSERT_RST(a_reset, i_clk, i_rst_n, empty && !full)

endmodule

bind ecdsa_der_signature_to_raw dsr_checker #(
    .INT_BYTES (INT_BYTES)
) u_dsr_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .full           (full),
    .o_raw_byte     (o_raw_byte),
    .o_raw_index    (o_raw_index),
    .o_final_result (o_final_result),
    .o_failed       (o_failed),
    .empty          (empty),
    .pop            (pop)
);

`default_nettype wire
